// File: sv/smfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smfd_pkg - shared types and constants of the measurement frame decoder
// Frame layout, CRC-8 step, status codes, register indexes and the structs
// that travel between the frame assembler and the scaling stages.
// ----------------------------------------------------------------------------
package smfd_pkg;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [3:0]  FRAME_LAST  = 4'd8;
    localparam logic [3:0]  FRAME_LEN   = 4'd9;

    // temperature = floor(17500*raw/65535) - 4500, humidity = floor(10000*raw/65535)
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [16:0] DIV_CONST   = 17'd65535;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CRC_ERR   = 2'd1,
        ST_RANGE_ERR = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_CO2_MIN  = 3'd0,
        CFG_CO2_MAX  = 3'd1,
        CFG_TEMP_MIN = 3'd2,
        CFG_TEMP_MAX = 3'd3,
        CFG_HUM_MIN  = 3'd4,
        CFG_HUM_MAX  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] co2;
        logic [15:0] temp;
        logic [15:0] hum;
        logic        crc_bad;
    } t_frame_words;

    typedef struct packed {
        logic [15:0] co2_min;
        logic [15:0] co2_max;
        logic [15:0] temp_min;
        logic [15:0] temp_max;
        logic [15:0] hum_min;
        logic [15:0] hum_max;
    } t_limits;

    // MSB-first CRC-8 over one byte, no reflection, no final xor
    function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: sv/smfd_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smfd_scale - range check and unit conversion of one decoded frame
// Stage one checks the windows and multiplies by the scale factors; stage two
// divides by 65535 with one correction step and forms the result word.
// ----------------------------------------------------------------------------
module smfd_scale
    import smfd_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire t_frame_words i_words,
    input  wire t_limits      i_limits,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [15:0]       o_co2_ppm,
    output logic [14:0]       o_temp_centi,
    output logic [13:0]       o_hum_centi,
    output logic [1:0]        o_status
);

    logic        r_v2;
    logic [15:0] r_co2;
    t_status     r_status;
    logic [30:0] r_tprod;
    logic [29:0] r_hprod;

    logic        r_ov;
    logic [15:0] r_out_co2;
    logic [14:0] r_out_temp;
    logic [13:0] r_out_hum;
    logic [1:0]  r_out_status;

    logic        out_ready;
    logic        s2_ready;
    logic        range_ok;
    t_status     n_status;
    logic [14:0] t_q0;
    logic [16:0] t_rem;
    logic [14:0] t_q;
    logic [13:0] h_q0;
    logic [16:0] h_rem;
    logic [13:0] h_q;
    logic        res_ok;

    assign out_ready = !r_ov || i_ready;
    assign s2_ready  = !r_v2 || out_ready;
    assign o_ready   = s2_ready;

    always_comb begin
        range_ok = (i_words.co2  >= i_limits.co2_min)  && (i_words.co2  <= i_limits.co2_max)
                && (i_words.temp >= i_limits.temp_min) && (i_words.temp <= i_limits.temp_max)
                && (i_words.hum  >= i_limits.hum_min)  && (i_words.hum  <= i_limits.hum_max);
        priority if (i_words.crc_bad) begin
            n_status = ST_CRC_ERR;
        end else if (!range_ok) begin
            n_status = ST_RANGE_ERR;
        end else begin
            n_status = ST_OK;
        end
    end

    // x / 65535: q0 = x >> 16 leaves remainder (x & 0xFFFF) + q0 < 2*65535
    always_comb begin
        t_q0  = r_tprod[30:16];
        t_rem = {1'b0, r_tprod[15:0]} + {2'b00, t_q0};
        t_q   = (t_rem >= DIV_CONST) ? t_q0 + 15'd1 : t_q0;
        h_q0  = r_hprod[29:16];
        h_rem = {1'b0, r_hprod[15:0]} + {3'b000, h_q0};
        h_q   = (h_rem >= DIV_CONST) ? h_q0 + 14'd1 : h_q0;
        res_ok = (r_status == ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (s2_ready) begin
                r_v2 <= i_valid;
            end
            if (out_ready) begin
                r_ov <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && i_valid) begin
            r_co2    <= i_words.co2;
            r_status <= n_status;
            r_tprod  <= {16'd0, TEMP_SCALE} * {15'd0, i_words.temp};
            r_hprod  <= {16'd0, HUM_SCALE} * {14'd0, i_words.hum};
        end
        if (out_ready && r_v2) begin
            r_out_co2    <= res_ok ? r_co2 : 16'd0;
            r_out_temp   <= res_ok ? t_q - TEMP_OFFSET : 15'd0;
            r_out_hum    <= res_ok ? h_q : 14'd0;
            r_out_status <= r_status;
        end
    end

    assign o_valid      = r_ov;
    assign o_co2_ppm    = r_out_co2;
    assign o_temp_centi = r_out_temp;
    assign o_hum_centi  = r_out_hum;
    assign o_status     = r_out_status;

endmodule
`default_nettype wire

// File: sv/sensor_measurement_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_measurement_frame_decoder - CRC-checked sensor measurement frame
// Assembles 9-byte frames (three big-endian words, each followed by a CRC-8
// byte, poly 0x31, init 0xFF) and emits CO2, temperature and humidity.
// ----------------------------------------------------------------------------
// Usage: the block takes one frame byte per clock cycle while s_axis_tready
// is high, with no gaps needed. The CRC of each byte is a single unrolled
// step, so the byte rate is limited only by s_axis_tready. After the ninth
// byte of a frame a result word reaches the master side through the frame
// register, multiply stage, divide and output register. A byte with tuser
// set always starts a new frame and drops any partial one; otherwise frames
// follow each other back to back. Status 1 flags a CRC mismatch in any word,
// status 2 a raw word outside its [min, max] window (a window with min above
// max rejects everything); on either failure the measurement fields are zero.
// Write the threshold registers only while no frame is in flight.
// ----------------------------------------------------------------------------
module sensor_measurement_frame_decoder
    import smfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
    input  wire logic        s_axis_tuser,   // [0] frame_start
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [15:0] co2_ppm, [30:16] temp_centi,
                                             // [44:31] hum_centi, [47:45] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] status
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    // threshold registers
    t_limits      r_limits;

    // frame assembly state
    logic [3:0]   r_pos;
    logic [7:0]   r_crc;
    logic [7:0]   r_hi;
    logic [15:0]  r_co2w;
    logic [15:0]  r_tempw;
    logic [15:0]  r_humw;
    logic         r_fail;

    logic [3:0]   n_pos;
    logic [7:0]   n_crc;
    logic [7:0]   n_hi;
    logic [15:0]  n_co2w;
    logic [15:0]  n_tempw;
    logic [15:0]  n_humw;
    logic         n_fail;

    // completed frame, waiting for the scaling stages
    logic         r_frm_valid;
    t_frame_words r_frm;

    logic         s_fire;
    logic         frm_ready;
    logic         scale_ready;
    logic         frame_done;
    logic         fail_now;
    logic [3:0]   pos_e;
    logic [7:0]   crc_e;
    logic         fail_e;
    logic [7:0]   crc_next;

    logic [15:0]  res_co2;
    logic [14:0]  res_temp;
    logic [13:0]  res_hum;
    logic [1:0]   res_status;

    assign frm_ready     = !r_frm_valid || scale_ready;
    assign s_axis_tready = frm_ready;
    assign s_fire        = s_axis_tvalid && frm_ready;

    // ---- configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.co2_min  <= 16'd300;
            r_limits.co2_max  <= 16'd5000;
            r_limits.temp_min <= 16'd9363;
            r_limits.temp_max <= 16'd39321;
            r_limits.hum_min  <= 16'd656;
            r_limits.hum_max  <= 16'd65535;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CO2_MIN:  r_limits.co2_min  <= i_cfg_data;
                CFG_CO2_MAX:  r_limits.co2_max  <= i_cfg_data;
                CFG_TEMP_MIN: r_limits.temp_min <= i_cfg_data;
                CFG_TEMP_MAX: r_limits.temp_max <= i_cfg_data;
                CFG_HUM_MIN:  r_limits.hum_min  <= i_cfg_data;
                CFG_HUM_MAX:  r_limits.hum_max  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---- frame assembly: restart on a start flag or after a full frame
    always_comb begin
        if (s_axis_tuser || (r_pos >= FRAME_LEN)) begin
            pos_e  = 4'd0;
            crc_e  = CRC_INIT;
            fail_e = 1'b0;
        end else begin
            pos_e  = r_pos;
            crc_e  = r_crc;
            fail_e = r_fail;
        end
        crc_next = crc8_byte(crc_e, s_axis_tdata);
    end

    always_comb begin
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_hi       = r_hi;
        n_co2w     = r_co2w;
        n_tempw    = r_tempw;
        n_humw     = r_humw;
        n_fail     = r_fail;
        fail_now   = fail_e;
        frame_done = 1'b0;
        if (s_fire) begin
            unique case (pos_e)
                4'd0, 4'd3, 4'd6: begin
                    n_crc = crc_next;
                    n_hi  = s_axis_tdata;
                end
                4'd1: begin
                    n_crc  = crc_next;
                    n_co2w = {r_hi, s_axis_tdata};
                end
                4'd4: begin
                    n_crc   = crc_next;
                    n_tempw = {r_hi, s_axis_tdata};
                end
                4'd7: begin
                    n_crc  = crc_next;
                    n_humw = {r_hi, s_axis_tdata};
                end
                default: begin
                    // check byte: compare and restart the accumulator
                    n_crc    = CRC_INIT;
                    fail_now = fail_e || (crc_e != s_axis_tdata);
                end
            endcase
            if (pos_e == FRAME_LAST) begin
                frame_done = 1'b1;
                n_pos      = 4'd0;
                n_fail     = 1'b0;
            end else begin
                n_pos  = pos_e + 4'd1;
                n_fail = fail_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 4'd0;
            r_crc   <= CRC_INIT;
            r_hi    <= 8'd0;
            r_co2w  <= 16'd0;
            r_tempw <= 16'd0;
            r_humw  <= 16'd0;
            r_fail  <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_hi    <= n_hi;
            r_co2w  <= n_co2w;
            r_tempw <= n_tempw;
            r_humw  <= n_humw;
            r_fail  <= n_fail;
        end
    end

    // ---- hold the completed frame until the scaling stages take it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frm_valid <= 1'b0;
        end else if (frm_ready) begin
            r_frm_valid <= frame_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_done) begin
            r_frm.co2     <= r_co2w;
            r_frm.temp    <= r_tempw;
            r_frm.hum     <= r_humw;
            r_frm.crc_bad <= fail_now;
        end
    end

    smfd_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_frm_valid),
        .o_ready      (scale_ready),
        .i_words      (r_frm),
        .i_limits     (r_limits),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_co2_ppm    (res_co2),
        .o_temp_centi (res_temp),
        .o_hum_centi  (res_hum),
        .o_status     (res_status)
    );

    assign m_axis_tdata = {3'b000, res_hum, res_temp, res_co2};
    assign m_axis_tuser = res_status;

endmodule
`default_nettype wire
